FILE: sv/wrb_pkg.sv
// Package for the windowed range breakout block: widths, scale constants,
// register indexes and the control struct shared by the datapath units.
// No dependencies.
package wrb_pkg;

   localparam int unsigned SYM_W   = 4;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned PRICE_W = 32;
   localparam int unsigned WIN_W   = 22;
   localparam int unsigned LIMIT_W = 24;
   localparam int unsigned BPS_W   = 24;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 1'd1;

   localparam logic [WIN_W-1:0]   WINDOW_RESET = 22'd30000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 24'd2048;

   // 256 * 20000 and 256 * 10000 (1/256 bps scaling).
   localparam logic [22:0] RANGE_SCALE = 23'd5120000;
   localparam logic [22:0] BREAK_SCALE = 23'd2560000;
   localparam logic [BPS_W-1:0] BPS_MAX = {BPS_W{1'b1}};

   // Numerator width: 33-bit difference times a 23-bit scale.
   localparam int unsigned NUM_W = 56;
   localparam int unsigned DEN_W = 33;

   typedef struct packed {
      logic                 start;
      logic [NUM_W-1:0]     numer;
      logic [DEN_W-1:0]     denom;
   } div_req_type;

endpackage

FILE: sv/windowed_range_breakout_top.sv
// Top level of the windowed range breakout block: sequencer, ring state and
// history memories. Depends on wrb_pkg, wrb_ram and wrb_div.
//
//   channel | direction | fields (tdata low bit up)                       | tuser
//   req     | in        | symbol_index, timestamp_ms, mid_price, pad       | none
//   rsp     | out       | recent_high, recent_low, mid_range_twice,        | none
//           |           | range_bps, breakout_bps, is_compressed,          |
//           |           | breakout_up, breakout_down, pad                  |
//   csr     | in        | index 0 window_ms, index 1 compress_limit        | none
//
// Each request trims the entries older than window_ms, scans the entries left
// (at most HISTORY_DEPTH) and makes up to two passes of the shared serial
// divider (range, then breakout); a pass is skipped when the low price is zero
// or there is no breakout to measure, and both when no entry is left to scan.
// Each trim or scan step addresses the memory, then reads its registered port.
// The block takes a request only in its idle state; the result stays in an
// output register until taken, and the next request is accepted meanwhile.
// Reset is synchronous and clears ring heads and counts; memories need no clear.
module windowed_range_breakout_top #(
   parameter int unsigned NUM_SYMBOLS   = 16,
   parameter int unsigned HISTORY_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [87:0]   req_tdata,   // symbol_index, timestamp_ms, mid_price
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,   // high, low, mid2, range, brk, comp, up, down
   input  logic          csr_wr_en,
   input  logic [wrb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wrb_pkg::CSR_W-1:0]     csr_data
);
   import wrb_pkg::*;

   localparam int unsigned SIDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int unsigned HPTR_W = $clog2(HISTORY_DEPTH);
   localparam int unsigned HCNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned MEM_DEPTH = NUM_SYMBOLS * HISTORY_DEPTH;
   localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TRIM_A = 4'd1;
   localparam logic [3:0] ST_TRIM_R = 4'd2;
   localparam logic [3:0] ST_SCAN_A = 4'd3;
   localparam logic [3:0] ST_SCAN_R = 4'd4;
   localparam logic [3:0] ST_RANGE  = 4'd5;
   localparam logic [3:0] ST_RWAIT  = 4'd6;
   localparam logic [3:0] ST_BRK    = 4'd7;
   localparam logic [3:0] ST_BWAIT  = 4'd8;
   localparam logic [3:0] ST_WRITE  = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;

   logic [WIN_W-1:0]   window_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic [HPTR_W-1:0] head_ff [NUM_SYMBOLS];
   logic [HCNT_W-1:0] count_ff [NUM_SYMBOLS];

   logic [SIDX_W-1:0]  sym_ff, sym_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [HPTR_W-1:0]  hd_ff, hd_in;
   logic [HCNT_W-1:0]  cnt_ff, cnt_in;
   logic [HCNT_W-1:0]  idx_ff, idx_in;
   logic [PRICE_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [BPS_W-1:0]   rng_ff, rng_in, brk_ff, brk_in;
   logic               up_ff, up_in, dn_ff, dn_in, comp_ff, comp_in;
   logic               out_v_ff, out_v_in;
   logic [151:0]       out_d_ff, out_d_in;

   logic              mem_we;
   logic [HPTR_W-1:0] slot;
   logic [ADDR_W-1:0] addr;
   logic [PRICE_W-1:0] rd_price;
   logic [TIME_W-1:0]  rd_time;
   logic [TIME_W:0]    age;

   div_req_type       dreq;
   logic              ddone;
   logic [BPS_W-1:0]  dquo;

   logic [SIDX_W-1:0] req_sym;
   logic              take;
   logic [DEN_W-1:0]  sum;

   assign req_sym = SIDX_W'(32'(req_tdata[SYM_W-1:0]) % NUM_SYMBOLS);
   assign take = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign sum = {1'b0, hi_ff} + {1'b0, lo_ff};
   assign age = {1'b0, now_ff} - {1'b0, rd_time};

   always_comb begin
      slot = HPTR_W'(({1'b0, hd_ff} + (HPTR_W + 1)'(idx_ff)) % HISTORY_DEPTH);
      if (state_ff == ST_WRITE) begin
         slot = HPTR_W'(({1'b0, hd_ff} + (HPTR_W + 1)'(cnt_ff)) % HISTORY_DEPTH);
      end
      addr = ADDR_W'(32'(sym_ff) * HISTORY_DEPTH + 32'(slot));
   end

   wrb_ram #(.WIDTH(PRICE_W), .DEPTH(MEM_DEPTH)) u_price_ram (
      .clock(clock), .wr_en(mem_we), .addr(addr), .wr_data(price_ff),
      .rd_data(rd_price));
   wrb_ram #(.WIDTH(TIME_W), .DEPTH(MEM_DEPTH)) u_time_ram (
      .clock(clock), .wr_en(mem_we), .addr(addr), .wr_data(now_ff),
      .rd_data(rd_time));

   wrb_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone),
      .quotient(dquo));

   always_comb begin
      state_in = state_ff;
      sym_in = sym_ff; now_in = now_ff; price_in = price_ff;
      hd_in = hd_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      hi_in = hi_ff; lo_in = lo_ff; rng_in = rng_ff; brk_in = brk_ff;
      up_in = up_ff; dn_in = dn_ff; comp_in = comp_ff;
      out_v_in = out_v_ff; out_d_in = out_d_ff;
      mem_we = 1'b0;
      dreq.start = 1'b0;
      dreq.numer = '0;
      dreq.denom = '0;
      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               sym_in   = req_sym;
               now_in   = req_tdata[SYM_W +: TIME_W];
               price_in = req_tdata[SYM_W + TIME_W +: PRICE_W];
               hd_in    = head_ff[req_sym];
               cnt_in   = count_ff[req_sym];
               idx_in   = '0;
               rng_in = '0; brk_in = '0; up_in = 1'b0; dn_in = 1'b0;
               state_in = ST_TRIM_A;
            end
         end
         ST_TRIM_A: begin
            if (cnt_ff == '0) begin
               state_in = ST_SCAN_A;
            end else begin
               state_in = ST_TRIM_R;
            end
         end
         ST_TRIM_R: begin
            if (!age[TIME_W] && (age[TIME_W-1:0] > TIME_W'(window_ff))) begin
               hd_in  = HPTR_W'(({1'b0, hd_ff} + 1'b1) % HISTORY_DEPTH);
               cnt_in = cnt_ff - 1'b1;
               state_in = ST_TRIM_A;
            end else begin
               state_in = ST_SCAN_A;
            end
            hi_in = '0;
            lo_in = '1;
         end
         ST_SCAN_A: begin
            if (cnt_ff == '0) begin
               hi_in = price_ff; lo_in = price_ff; comp_in = 1'b1;
               state_in = ST_WRITE;
            end else if (idx_ff == cnt_ff) begin
               state_in = ST_RANGE;
            end else begin
               state_in = ST_SCAN_R;
            end
         end
         ST_SCAN_R: begin
            if (rd_price > hi_ff) hi_in = rd_price;
            if (rd_price < lo_ff) lo_in = rd_price;
            idx_in = idx_ff + 1'b1;
            state_in = ST_SCAN_A;
         end
         ST_RANGE: begin
            up_in = price_ff > hi_ff;
            dn_in = price_ff < lo_ff;
            if (lo_ff != '0) begin
               dreq.start = 1'b1;
               dreq.numer = NUM_W'(33'(hi_ff - lo_ff) * 56'(RANGE_SCALE));
               dreq.denom = sum;
               state_in = ST_RWAIT;
            end else begin
               comp_in = 1'b1;
               state_in = ST_BRK;
            end
         end
         ST_RWAIT: begin
            if (ddone) begin
               rng_in = dquo;
               comp_in = dquo <= limit_ff;
               state_in = ST_BRK;
            end
         end
         ST_BRK: begin
            state_in = ST_WRITE;
            if (up_ff && hi_ff != '0) begin
               dreq.start = 1'b1;
               dreq.numer = NUM_W'(56'(price_ff - hi_ff) * 56'(BREAK_SCALE));
               dreq.denom = DEN_W'(hi_ff);
               state_in = ST_BWAIT;
            end else if (dn_ff && price_ff != '0) begin
               dreq.start = 1'b1;
               dreq.numer = NUM_W'(56'(lo_ff - price_ff) * 56'(BREAK_SCALE));
               dreq.denom = DEN_W'(lo_ff);
               state_in = ST_BWAIT;
            end
         end
         ST_BWAIT: begin
            if (ddone) begin
               brk_in = dquo;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_v_ff) begin
               out_v_in = 1'b1;
               out_d_in = {4'b0, dn_ff, up_ff, comp_ff, brk_ff, rng_ff, sum,
                           lo_ff, hi_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         out_v_ff  <= 1'b0;
         window_ff <= WINDOW_RESET;
         limit_ff  <= LIMIT_RESET;
         for (int s = 0; s < NUM_SYMBOLS; s++) begin
            head_ff[s]  <= '0;
            count_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW: window_ff <= csr_data[WIN_W-1:0];
               CSR_LIMIT:  limit_ff  <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_WRITE) begin
            if (cnt_ff == HCNT_W'(HISTORY_DEPTH)) begin
               head_ff[sym_ff]  <= HPTR_W'(({1'b0, hd_ff} + 1'b1) % HISTORY_DEPTH);
               count_ff[sym_ff] <= cnt_ff;
            end else begin
               head_ff[sym_ff]  <= hd_ff;
               count_ff[sym_ff] <= cnt_ff + 1'b1;
            end
         end
      end
      sym_ff <= sym_in; now_ff <= now_in; price_ff <= price_in;
      hd_ff <= hd_in; cnt_ff <= cnt_in; idx_ff <= idx_in;
      hi_ff <= hi_in; lo_ff <= lo_in; rng_ff <= rng_in; brk_ff <= brk_in;
      up_ff <= up_in; dn_ff <= dn_in; comp_ff <= comp_in;
      out_d_ff <= out_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
endmodule

FILE: sv/wrb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module wrb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/wrb_div.sv
// Restoring serial divider: one quotient bit per cycle, saturating to 24 bits.
// Depends on wrb_pkg.
module wrb_div (
   input  logic                       clock,
   input  logic                       reset,
   input  wrb_pkg::div_req_type       req,
   output logic                       done,
   output logic [wrb_pkg::BPS_W-1:0]  quotient
);
   import wrb_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         quo_in  = req.numer;
         rem_in  = '0;
         den_in  = req.denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[NUM_W-1:BPS_W]) ? BPS_MAX : quo_ff[BPS_W-1:0];
endmodule

FILE: sv/wrb_checker.sv
// Port-level checker for the windowed range breakout block, bound to the top.
// Depends on the top level's port list only.
module wrb_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata
);
   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Recorded twice-midpoint field equals high plus low.
   a_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[96:64] == {1'b0, rsp_tdata[31:0]} + {1'b0, rsp_tdata[63:32]})
      else $error("midpoint mismatch");

   // Up and down breakout never both set.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[146] && rsp_tdata[147]))
      else $error("both breakout flags set");

   // Accepting a request while no response is pending is not followed by a response in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response too early");
endmodule

bind windowed_range_breakout_top wrb_checker u_wrb_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
